### sv/gfhs_pkg.sv
package gfhs_pkg;

    localparam int unsigned MaxNodes  = 32;
    localparam int unsigned NodeW     = $clog2(MaxNodes);
    localparam int unsigned CountW    = $clog2(MaxNodes + 1);
    localparam int unsigned StepW     = 3;
    localparam int unsigned ProgDepth = 2 ** StepW;

    localparam logic [CountW-1:0] CountReset = CountW'(MaxNodes);

    typedef logic [StepW-1:0]    t_step;
    typedef logic [MaxNodes-1:0] t_row;

    typedef enum logic {
        ACT_ADD_EDGE = 1'b0,
        ACT_QUERY    = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        OP_LATCH,
        OP_EDGE,
        OP_INIT,
        OP_GROW,
        OP_SWEEP_END,
        OP_NEIGH,
        OP_SCAN,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_ACCEPT,
        C_IS_EDGE,
        C_TRIVIAL,
        C_MORE_IDX,
        C_CHANGED,
        C_SCAN_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ucode;

    // Step addresses of the control program
    localparam t_step StWait     = 3'd0;
    localparam t_step StDispatch = 3'd1;
    localparam t_step StInit     = 3'd2;
    localparam t_step StGrow     = 3'd3;
    localparam t_step StSweepEnd = 3'd4;
    localparam t_step StNeigh    = 3'd5;
    localparam t_step StScan     = 3'd6;
    localparam t_step StEmit     = 3'd7;

    // Jump taken when cond holds, else fall through to step + 1.
    // The emit step falls through by wrapping to the wait step.
    function automatic t_ucode ucode_rom(input t_step addr);
        t_ucode w;
        unique case (addr)
            StWait:     w = '{op: OP_LATCH,     cond: C_NO_ACCEPT, target: StWait};
            StDispatch: w = '{op: OP_EDGE,      cond: C_IS_EDGE,   target: StWait};
            StInit:     w = '{op: OP_INIT,      cond: C_TRIVIAL,   target: StEmit};
            StGrow:     w = '{op: OP_GROW,      cond: C_MORE_IDX,  target: StGrow};
            StSweepEnd: w = '{op: OP_SWEEP_END, cond: C_CHANGED,   target: StGrow};
            StNeigh:    w = '{op: OP_NEIGH,     cond: C_NEVER,     target: StWait};
            StScan:     w = '{op: OP_SCAN,      cond: C_SCAN_MORE, target: StScan};
            StEmit:     w = '{op: OP_EMIT,      cond: C_OUT_BUSY,  target: StEmit};
            default:    w = '{op: OP_LATCH,     cond: C_NEVER,     target: StWait};
        endcase
        return w;
    endfunction

endpackage

### sv/graph_first_hop_search_unit.sv
// Edge add: accepted in the wait step, adjacency written in the following dispatch step.
// Query: init, then straight to emit for out-of-range or source == target; else
//   S reachability sweeps (grow over nodes, sweep end), N = node count, S = 1..N-1,
//   then neighbor, scan and emit. The sweep loop reads one adjacency row per cycle.
// One item in work at a time; emit waits on a stalled result, then frees the input side.
// Reset (i_rst_n low, synchronous) clears all edges, sets node_count to 32, drops o_out_valid.
module graph_first_hop_search_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_action,
    input  logic [gfhs_pkg::NodeW-1:0] i_from_node,
    input  logic [gfhs_pkg::NodeW-1:0] i_to_node,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [gfhs_pkg::NodeW-1:0] o_next_hop,
    output logic                      o_found
);
    import gfhs_pkg::*;

    t_row              r_adj [MaxNodes];
    logic [CountW-1:0] r_node_count;
    t_step             r_step, n_step;
    t_action           r_action;
    logic [NodeW-1:0]  r_a, r_b;
    logic [NodeW-1:0]  r_idx;
    t_row              r_reach;
    t_row              r_neigh;
    logic              r_changed;
    logic [NodeW-1:0]  r_hop;
    logic              r_hit;
    logic              r_out_valid;
    logic [NodeW-1:0]  r_out_hop;
    logic              r_out_found;

    t_ucode            uw;
    logic              cfg_wr;
    logic [CountW-1:0] eff_count;
    t_row              mask;
    t_row              src_bit;
    t_row              dst_bit;
    t_row              row_rd;
    t_row              grown;
    logic              a_in, b_in;
    logic              idx_last;
    logic              out_busy;
    logic              in_accept;
    logic              cond_true;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - CountW){1'b0}}, r_node_count} : 32'd0;

    assign eff_count = (r_node_count > CountW'(MaxNodes)) ? CountW'(MaxNodes) : r_node_count;

    always_comb begin
        for (int k = 0; k < MaxNodes; k++) begin
            mask[k] = (CountW'(k) < eff_count);
        end
    end

    assign src_bit  = t_row'(1) << r_a;
    assign dst_bit  = t_row'(1) << r_b;
    assign row_rd   = r_adj[r_idx];
    assign grown    = r_reach | (row_rd & mask & ~src_bit);
    assign a_in     = {1'b0, r_a} < eff_count;
    assign b_in     = {1'b0, r_b} < eff_count;
    assign idx_last = ({1'b0, r_idx} + CountW'(1)) == eff_count;
    assign out_busy = r_out_valid && i_out_stall;

    assign uw         = ucode_rom(r_step);
    assign o_in_stall = (r_step != StWait);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Condition select and next step
    always_comb begin
        unique case (uw.cond)
            C_NEVER:     cond_true = 1'b0;
            C_NO_ACCEPT: cond_true = !i_in_valid;
            C_IS_EDGE:   cond_true = (r_action == ACT_ADD_EDGE);
            C_TRIVIAL:   cond_true = !a_in || !b_in || (r_a == r_b);
            C_MORE_IDX:  cond_true = !idx_last;
            C_CHANGED:   cond_true = r_changed;
            C_SCAN_MORE: cond_true = !r_neigh[r_idx] && !idx_last;
            C_OUT_BUSY:  cond_true = out_busy;
            default:     cond_true = 1'b0;
        endcase
        n_step = cond_true ? uw.target : r_step + t_step'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= StWait;
            r_node_count <= CountReset;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < MaxNodes; k++) begin
                r_adj[k] <= '0;
            end
        end else begin
            r_step <= n_step;
            if (cfg_wr) begin
                r_node_count <= pwdata[CountW-1:0];
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (uw.op == OP_EDGE && r_action == ACT_ADD_EDGE && a_in && b_in) begin
                for (int k = 0; k < MaxNodes; k++) begin
                    if (NodeW'(k) == r_a) begin
                        r_adj[k] <= r_adj[k] | dst_bit;
                    end else if (NodeW'(k) == r_b) begin
                        r_adj[k] <= r_adj[k] | src_bit;
                    end
                end
            end
            if (uw.op == OP_EMIT && !out_busy) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Datapath, driven by the control word
    always_ff @(posedge i_clk) begin
        unique case (uw.op)
            OP_LATCH: begin
                if (in_accept) begin
                    r_action <= t_action'(i_action);
                    r_a      <= i_from_node;
                    r_b      <= i_to_node;
                end
            end
            OP_EDGE: begin
            end
            OP_INIT: begin
                r_reach   <= t_row'(1) << r_b;
                r_idx     <= '0;
                r_changed <= 1'b0;
                r_hop     <= (a_in && b_in && r_a == r_b) ? r_a : '0;
                r_hit     <= a_in && b_in && (r_a == r_b);
            end
            OP_GROW: begin
                if (r_reach[r_idx]) begin
                    r_reach <= grown;
                    if (grown != r_reach) begin
                        r_changed <= 1'b1;
                    end
                end
                r_idx <= r_idx + NodeW'(1);
            end
            OP_SWEEP_END: begin
                // a fresh sweep restarts at node 0; otherwise point at the source row
                r_idx     <= r_changed ? '0 : r_a;
                r_changed <= 1'b0;
            end
            OP_NEIGH: begin
                r_neigh <= row_rd & mask & ~src_bit & r_reach;
                r_idx   <= '0;
            end
            OP_SCAN: begin
                if (r_neigh[r_idx]) begin
                    r_hop <= r_idx;
                    r_hit <= 1'b1;
                end
                r_idx <= r_idx + NodeW'(1);
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    r_out_hop   <= r_hop;
                    r_out_found <= r_hit;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_next_hop  = r_out_hop;
    assign o_found     = r_out_found;

endmodule
